// File: rtl/scws_pkg.sv
// ----------------------------------------------------------------------------
// scws_pkg
// Shared constants, types and helpers for the spring chain wave surface.
// ----------------------------------------------------------------------------
package scws_pkg;

  localparam int SPRING_COUNT  = 64;
  localparam int SPREAD_PASSES = 8;
  localparam int IDX_W         = $clog2(SPRING_COUNT);
  localparam int PASS_W        = $clog2(SPREAD_PASSES + 1);

  localparam int SPRING_INDEX_W = 6;
  localparam int Q_W            = 32;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int DIV_STEPS      = 16;
  localparam int DIVC_W         = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_TENSION   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DAMPENING = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPREAD    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEA_LEVEL = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BAR_WIDTH = 3'd4;

  localparam logic [15:0] TENSION_RST   = 16'd1638;
  localparam logic [15:0] DAMPENING_RST = 16'd1638;
  localparam logic [15:0] SPREAD_RST    = 16'd16384;
  localparam logic [11:0] SEA_LEVEL_RST = 12'd384;
  localparam logic [12:0] BAR_WIDTH_RST = 13'd16;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_TOUCH = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_T_DIV, S_T_RD, S_T_CAP, S_T_WR,
    S_D_RD, S_D_CAP, S_D_MT, S_D_MD, S_D_ACC, S_D_WR,
    S_P_RD0, S_P_CAP0, S_P_RDN, S_P_CAPN, S_P_MN, S_P_ACC, S_P_WR,
    S_O_RD, S_O_CAP, S_O_WAIT
  } state_t;

  typedef enum logic [1:0] {ADDR_CNT, ADDR_NEXT, ADDR_TOUCH} addr_sel_t;
  typedef enum logic [2:0] {
    MUL_NONE, MUL_TENSION, MUL_DAMP, MUL_SPREAD_PREV, MUL_SPREAD_NEXT
  } mul_op_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_CLEAR, ACC_SUB, ACC_ADD} acc_op_t;
  typedef enum logic [1:0] {WR_NONE, WR_DAMP, WR_SPREAD, WR_TOUCH} wr_op_t;

  typedef struct packed {
    logic             rd_en;
    addr_sel_t        rd_sel;
    wr_op_t           wr_op;
    logic             cap_cur;
    logic             cap_next;
    logic             shift;
    mul_op_t          mul_op;
    acc_op_t          acc_op;
    logic             div_start;
    logic             div_step;
    logic             out_cap;
    logic [IDX_W-1:0] spring;
  } cmd_t;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [35:0] x);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sd2147483647;
    lo = -36'sd2147483648;
    if (x > hi) begin
      return 32'sh7FFFFFFF;
    end else if (x < lo) begin
      return 32'sh80000000;
    end
    return x[Q_W-1:0];
  endfunction

endpackage

// File: rtl/spring_chain_wave_surface_top.sv
// ----------------------------------------------------------------------------
// spring_chain_wave_surface_top
// Damped spring chain water surface: touch impulses and per-tick updates.
// ----------------------------------------------------------------------------
// One item at a time. A touch runs a bit-serial divide that finds the nearest
// spring, then one read-modify-write of the spring store.
// A tick sweeps the spring store (one write port, one read port) through one
// shared multiply-round-accumulate unit: the damping sweep, then eight spread
// passes, then the output run of one height per spring, which waits on any
// output stall. The store resets to zero at once through per-spring valid
// bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module spring_chain_wave_surface_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic [15:0]                         touch_x,
  input  logic signed [scws_pkg::Q_W-1:0]     touch_velocity,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [scws_pkg::SPRING_INDEX_W-1:0] spring_index,
  output logic signed [scws_pkg::Q_W-1:0]     height,
  output logic                                last,
  input  logic                                cfg_we,
  input  logic [scws_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [scws_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import scws_pkg::*;

  cmd_t cmd;

  scws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  scws_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .touch_x        (touch_x),
    .touch_velocity (touch_velocity),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .spring_index   (spring_index),
    .height         (height),
    .last           (last)
  );

endmodule

// File: rtl/scws_ram.sv
// ----------------------------------------------------------------------------
// scws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scws_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/scws_ctrl.sv
// ----------------------------------------------------------------------------
// scws_ctrl
// Sequencer: touch division, damping sweep, spread passes, output run.
// ----------------------------------------------------------------------------
module scws_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          opcode,
  output logic          out_valid,
  input  logic          out_ready,
  output scws_pkg::cmd_t cmd
);
  import scws_pkg::*;

  state_t             state, state_next;
  logic [IDX_W-1:0]   cnt, cnt_next;
  logic [PASS_W-1:0]  pass, pass_next;
  logic [DIVC_W-1:0]  divc, divc_next;
  logic               accept;
  logic               cnt_last;
  logic               cnt_first;

  localparam logic [IDX_W-1:0]  CNT_LAST  = IDX_W'(SPRING_COUNT - 1);
  localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(SPREAD_PASSES - 1);
  localparam logic [DIVC_W-1:0] DIVC_LAST = DIVC_W'(DIV_STEPS - 1);

  assign accept    = in_valid && in_ready;
  assign cnt_last  = (cnt == CNT_LAST);
  assign cnt_first = (cnt == '0);
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_O_WAIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pass  <= '0;
      divc  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pass  <= pass_next;
      divc  <= divc_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pass_next  = pass;
    divc_next  = divc;
    case (state)
      S_IDLE: begin
        cnt_next  = '0;
        pass_next = '0;
        divc_next = '0;
        if (accept) begin
          state_next = (opcode == OP_TOUCH) ? S_T_DIV : S_D_RD;
        end
      end
      S_T_DIV: begin
        divc_next = divc + 1'b1;
        if (divc == DIVC_LAST) begin
          state_next = S_T_RD;
        end
      end
      S_T_RD:  state_next = S_T_CAP;
      S_T_CAP: state_next = S_T_WR;
      S_T_WR:  state_next = S_IDLE;
      S_D_RD:  state_next = S_D_CAP;
      S_D_CAP: state_next = S_D_MT;
      S_D_MT:  state_next = S_D_MD;
      S_D_MD:  state_next = S_D_ACC;
      S_D_ACC: state_next = S_D_WR;
      S_D_WR: begin
        if (cnt_last) begin
          cnt_next   = '0;
          state_next = S_P_RD0;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = S_D_RD;
        end
      end
      S_P_RD0:  state_next = S_P_CAP0;
      S_P_CAP0: state_next = S_P_RDN;
      S_P_RDN:  state_next = S_P_CAPN;
      S_P_CAPN: state_next = S_P_MN;
      S_P_MN:   state_next = S_P_ACC;
      S_P_ACC:  state_next = S_P_WR;
      S_P_WR: begin
        if (!cnt_last) begin
          cnt_next   = cnt + 1'b1;
          state_next = S_P_RDN;
        end else if (pass == PASS_LAST) begin
          cnt_next   = '0;
          state_next = S_O_RD;
        end else begin
          cnt_next   = '0;
          pass_next  = pass + 1'b1;
          state_next = S_P_RD0;
        end
      end
      S_O_RD:  state_next = S_O_CAP;
      S_O_CAP: state_next = S_O_WAIT;
      S_O_WAIT: begin
        if (out_ready) begin
          if (cnt_last) begin
            state_next = S_IDLE;
          end else begin
            cnt_next   = cnt + 1'b1;
            state_next = S_O_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = ADDR_CNT;
    cmd.wr_op     = WR_NONE;
    cmd.mul_op    = MUL_NONE;
    cmd.acc_op    = ACC_HOLD;
    cmd.spring    = cnt;
    case (state)
      S_IDLE:  cmd.div_start = accept;
      S_T_DIV: cmd.div_step  = 1'b1;
      S_T_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_TOUCH;
      end
      S_T_CAP: cmd.cap_cur = 1'b1;
      S_T_WR:  cmd.wr_op   = WR_TOUCH;
      S_D_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.acc_op = ACC_CLEAR;
      end
      S_D_CAP: cmd.cap_cur = 1'b1;
      S_D_MT:  cmd.mul_op  = MUL_TENSION;
      S_D_MD: begin
        cmd.mul_op = MUL_DAMP;
        cmd.acc_op = ACC_SUB;
      end
      S_D_ACC: cmd.acc_op = ACC_SUB;
      S_D_WR:  cmd.wr_op  = WR_DAMP;
      S_P_RD0: cmd.rd_en  = 1'b1;
      S_P_CAP0: cmd.cap_cur = 1'b1;
      S_P_RDN: begin
        cmd.rd_en  = !cnt_last;
        cmd.rd_sel = ADDR_NEXT;
        cmd.acc_op = ACC_CLEAR;
      end
      S_P_CAPN: begin
        cmd.cap_next = !cnt_last;
        if (!cnt_first) begin
          cmd.mul_op = MUL_SPREAD_PREV;
        end
      end
      S_P_MN: begin
        if (!cnt_first) begin
          cmd.acc_op = ACC_ADD;
        end
        if (!cnt_last) begin
          cmd.mul_op = MUL_SPREAD_NEXT;
        end
      end
      S_P_ACC: begin
        if (!cnt_last) begin
          cmd.acc_op = ACC_ADD;
        end
      end
      S_P_WR: begin
        cmd.wr_op = WR_SPREAD;
        cmd.shift = 1'b1;
      end
      S_O_RD:  cmd.rd_en   = 1'b1;
      S_O_CAP: cmd.out_cap = 1'b1;
      S_O_WAIT: ;
      default: ;
    endcase
  end

endmodule

// File: rtl/scws_datapath.sv
// ----------------------------------------------------------------------------
// scws_datapath
// Spring store, shared multiply-round-accumulate unit, touch divider,
// configuration registers and output register.
// ----------------------------------------------------------------------------
module scws_datapath (
  input  logic                                     clk,
  input  logic                                     rst,
  input  scws_pkg::cmd_t                           cmd,
  input  logic [15:0]                              touch_x,
  input  logic signed [scws_pkg::Q_W-1:0]          touch_velocity,
  input  logic                                     cfg_we,
  input  logic [scws_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [scws_pkg::CFG_DATA_W-1:0]          cfg_data,
  output logic [scws_pkg::SPRING_INDEX_W-1:0]      spring_index,
  output logic signed [scws_pkg::Q_W-1:0]          height,
  output logic                                     last
);
  import scws_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SPRING_COUNT - 1);

  logic [15:0] tension, dampening, spread;
  logic [11:0] sea_level;
  logic [12:0] bar_width;

  logic [SPRING_COUNT-1:0] valid;
  logic                    rd_valid;
  logic [2*Q_W-1:0]        rdata, rdata_m, wdata;
  logic [IDX_W-1:0]        raddr, waddr;
  logic                    we;

  logic signed [Q_W-1:0] prev_d, cur_d, cur_v, next_d, next_v, tv;
  logic signed [49:0]    prod;
  logic signed [35:0]    acc;
  logic signed [33:0]    rnd;
  logic [15:0]           mul_f;
  logic signed [32:0]    mul_x;

  logic [15:0] quo;
  logic [12:0] rem;
  logic [13:0] rem_sh;
  logic [16:0] idx_raw;
  logic [IDX_W-1:0] touch_idx;

  logic signed [35:0] height_sum;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tension   <= TENSION_RST;
      dampening <= DAMPENING_RST;
      spread    <= SPREAD_RST;
      sea_level <= SEA_LEVEL_RST;
      bar_width <= BAR_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TENSION:   tension   <= cfg_data;
        REG_DAMPENING: dampening <= cfg_data;
        REG_SPREAD:    spread    <= cfg_data;
        REG_SEA_LEVEL: sea_level <= cfg_data[11:0];
        REG_BAR_WIDTH: bar_width <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // touch: restoring divide, one quotient bit a cycle
  assign rem_sh = {rem, quo[15]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= touch_x;
      rem <= '0;
      tv  <= touch_velocity;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, bar_width}) begin
        rem <= 13'(rem_sh - {1'b0, bar_width});
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= rem_sh[12:0];
        quo <= {quo[14:0], 1'b0};
      end
    end
  end

  always_comb begin
    if ({rem, 1'b0} <= {1'b0, bar_width}) begin
      idx_raw = {1'b0, quo};
    end else begin
      idx_raw = {1'b0, quo} + 17'd1;
    end
    if (bar_width == '0) begin
      touch_idx = '0;
    end else if (idx_raw > 17'(SPRING_COUNT - 1)) begin
      touch_idx = IDX_LAST;
    end else begin
      touch_idx = idx_raw[IDX_W-1:0];
    end
  end

  // spring store; an entry never written reads as zero
  always_comb begin
    case (cmd.rd_sel)
      ADDR_NEXT:  raddr = cmd.spring + 1'b1;
      ADDR_TOUCH: raddr = touch_idx;
      default:    raddr = cmd.spring;
    endcase
  end

  assign we      = (cmd.wr_op != WR_NONE);
  assign waddr   = (cmd.wr_op == WR_TOUCH) ? touch_idx : cmd.spring;
  assign rdata_m = rd_valid ? rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid <= valid[raddr];
      end
    end
  end

  scws_ram #(
    .WIDTH (2 * Q_W),
    .DEPTH (SPRING_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (cmd.wr_op)
      WR_DAMP: wdata = {sat32(36'(cur_d) + 36'(cur_v)), sat32(36'(cur_v) + acc)};
      WR_SPREAD: wdata = {sat32(36'(cur_d) + acc), sat32(36'(cur_v) + acc)};
      WR_TOUCH: wdata = {cur_d, sat32(36'(cur_v) + 36'(tv))};
      default: wdata = {cur_d, cur_v};
    endcase
  end

  // working registers: previous snapshot, current and next spring
  always_ff @(posedge clk) begin
    if (cmd.cap_cur) begin
      cur_d <= rdata_m[2*Q_W-1:Q_W];
      cur_v <= rdata_m[Q_W-1:0];
    end else if (cmd.shift) begin
      prev_d <= cur_d;
      cur_d  <= next_d;
      cur_v  <= next_v;
    end
    if (cmd.cap_next) begin
      next_d <= rdata_m[2*Q_W-1:Q_W];
      next_v <= rdata_m[Q_W-1:0];
    end
  end

  // shared multiply, then round to nearest (ties up) and accumulate
  always_comb begin
    case (cmd.mul_op)
      MUL_TENSION: begin
        mul_f = tension;
        mul_x = 33'(cur_d);
      end
      MUL_DAMP: begin
        mul_f = dampening;
        mul_x = 33'(cur_v);
      end
      MUL_SPREAD_PREV: begin
        mul_f = spread;
        mul_x = 33'(prev_d) - 33'(cur_d);
      end
      MUL_SPREAD_NEXT: begin
        mul_f = spread;
        mul_x = 33'(next_d) - 33'(cur_d);
      end
      default: begin
        mul_f = '0;
        mul_x = '0;
      end
    endcase
  end

  assign rnd = 34'((prod + 50'sd32768) >>> 16);

  always_ff @(posedge clk) begin
    if (cmd.mul_op != MUL_NONE) begin
      prod <= $signed({1'b0, mul_f}) * mul_x;
    end
    case (cmd.acc_op)
      ACC_CLEAR: acc <= '0;
      ACC_SUB:   acc <= acc - 36'(rnd);
      ACC_ADD:   acc <= acc + 36'(rnd);
      default:   ;
    endcase
  end

  // output register
  assign height_sum = $signed({8'b0, sea_level, 16'b0})
                    + 36'($signed(rdata_m[2*Q_W-1:Q_W]));

  always_ff @(posedge clk) begin
    if (cmd.out_cap) begin
      spring_index <= SPRING_INDEX_W'(cmd.spring);
      height       <= sat32(height_sum);
      last         <= (cmd.spring == IDX_LAST);
    end
  end

endmodule

// File: rtl/scws_checker.sv
// ----------------------------------------------------------------------------
// scws_checker
// Port-level checks for the spring chain wave surface.
// ----------------------------------------------------------------------------
module scws_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                opcode,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [scws_pkg::SPRING_INDEX_W-1:0] spring_index,
  input logic signed [scws_pkg::Q_W-1:0]     height,
  input logic                                last
);
  import scws_pkg::*;

  // one transaction in flight: never take input while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (spring_index == SPRING_INDEX_W'(SPRING_COUNT - 1))))
    else $error("last flag does not match the final spring");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && opcode == OP_TICK) |=> (!in_ready && !out_valid))
    else $error("tick transaction did not start a sweep");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(height) && $stable(spring_index) && $stable(last)))
    else $error("stalled result changed");

endmodule

bind spring_chain_wave_surface_top scws_checker u_chk (.*);

// File: test/tb_spring_chain_wave_surface_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spring_chain_wave_surface_top
// Self-checking bench for the spring chain wave surface. Touch and tick
// transactions go in with random gaps, every height that comes out is checked
// against a fixed-point predictor of the chain, over several register settings.
// ----------------------------------------------------------------------------
module tb_spring_chain_wave_surface_top;
  import scws_pkg::*;

  typedef struct {
    logic [SPRING_INDEX_W-1:0] idx;
    logic signed [Q_W-1:0]     h;
    logic                      lst;
  } height_t;

  class surface_board;
    int                     disp[SPRING_COUNT];
    int                     vel[SPRING_COUNT];
    longint                 tension, damping, coupling, sea, bar;
    height_t                heights_due[$];
    int                     errors;
    int                     ticks, touches, checked;

    function void reset_state();
      for (int i = 0; i < SPRING_COUNT; i++) begin
        disp[i] = 0;
        vel[i]  = 0;
      end
      tension = TENSION_RST; damping = DAMPENING_RST; coupling = SPREAD_RST;
      sea = SEA_LEVEL_RST; bar = BAR_WIDTH_RST;
      errors = 0; ticks = 0; touches = 0; checked = 0;
    endfunction

    function int sat(longint x);
      if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return int'(x);
    endfunction

    // round to nearest, ties up: floor((f*x + 32768) / 65536)
    function longint scale(longint f, longint x);
      longint p;
      p = f * x + 32768;
      return p >>> 16;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TENSION:   tension  = data;
        REG_DAMPENING: damping  = data;
        REG_SPREAD:    coupling = data;
        REG_SEA_LEVEL: sea      = data[11:0];
        REG_BAR_WIDTH: bar      = data[12:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic op, logic [15:0] x, logic signed [Q_W-1:0] v);
      longint spring, q, r;
      longint gain[SPRING_COUNT];
      int     snap[SPRING_COUNT];
      longint d, dv, acc, diff;
      height_t e;
      if (op == OP_TOUCH) begin
        touches++;
        spring = 0;
        if (bar != 0) begin
          q = x / bar;
          r = x % bar;
          spring = (2 * r <= bar) ? q : q + 1;
        end
        if (spring > SPRING_COUNT - 1) spring = SPRING_COUNT - 1;
        vel[spring] = sat(longint'(vel[spring]) + longint'(v));
        return;
      end
      ticks++;
      for (int i = 0; i < SPRING_COUNT; i++) begin
        d   = disp[i];
        dv  = vel[i];
        acc = -scale(tension, d) - scale(damping, dv);
        disp[i] = sat(d + dv);
        vel[i]  = sat(dv + acc);
      end
      for (int p = 0; p < SPREAD_PASSES; p++) begin
        for (int i = 0; i < SPRING_COUNT; i++) begin
          snap[i] = disp[i];
          gain[i] = 0;
        end
        for (int i = 1; i < SPRING_COUNT; i++) begin
          diff = longint'(snap[i]) - longint'(snap[i-1]);
          gain[i-1] += scale(coupling, diff);
          gain[i]   += scale(coupling, -diff);
        end
        for (int i = 0; i < SPRING_COUNT; i++) begin
          vel[i]  = sat(longint'(vel[i]) + gain[i]);
          disp[i] = sat(longint'(disp[i]) + gain[i]);
        end
      end
      for (int i = 0; i < SPRING_COUNT; i++) begin
        e.idx = SPRING_INDEX_W'(i);
        e.h   = sat(sea * 65536 + longint'(disp[i]));
        e.lst = (i == SPRING_COUNT - 1);
        heights_due = {heights_due, e};
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [SPRING_INDEX_W-1:0] idx, logic signed [Q_W-1:0] h,
                      logic lst);
      height_t e;
      checked++;
      if (heights_due.size() == 0) begin
        report($sformatf("unexpected height idx=%0d h=%h", idx, h));
        return;
      end
      e = heights_due.pop_front();
      if (idx !== e.idx) report($sformatf("spring_index %0d, want %0d", idx, e.idx));
      if (h !== e.h)
        report($sformatf("height idx=%0d got %h, want %h", e.idx, h, e.h));
      if (lst !== e.lst) report($sformatf("last idx=%0d got %b", e.idx, lst));
    endtask
  endclass

  logic                       clk, rst;
  logic                       in_valid, in_ready;
  logic                       opcode;
  logic [15:0]                touch_x;
  logic signed [Q_W-1:0]      touch_velocity;
  logic                       out_valid, out_ready;
  logic [SPRING_INDEX_W-1:0]  spring_index;
  logic signed [Q_W-1:0]      height;
  logic                       last;
  logic                       cfg_we;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  surface_board board;
  int           stall_cycles;
  bit           held_off;

  spring_chain_wave_surface_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .touch_x(touch_x), .touch_velocity(touch_velocity),
    .out_valid(out_valid), .out_ready(out_ready),
    .spring_index(spring_index), .height(height), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task send_item(logic op, logic [15:0] x, logic signed [Q_W-1:0] v);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    touch_x        <= x;
    touch_velocity <= v;
    do @(posedge clk); while (!in_ready);
    board.note_input(op, x, v);
  endtask

  task send_random(int count);
    logic        op;
    logic [15:0] x;
    logic [31:0] v;
    longint      span;
    for (int n = 0; n < count; n++) begin
      op   = ($urandom_range(0, 99) < 30) ? OP_TICK : OP_TOUCH;
      span = board.bar * SPRING_COUNT;
      if (span > 65535) span = 65535;
      x = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 32'(span))) : 16'($urandom);
      if ($urandom_range(0, 99) < 70) v = $urandom_range(0, 32'h1FFFFF) - 32'h100000;
      else v = $urandom;
      send_item(op, x, v);
    end
  endtask

  // hold until nothing is due, then allow a touch in flight to finish
  task wait_idle();
    in_valid <= 1'b0;
    while (board.heights_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  task cfg_all(logic [15:0] t, logic [15:0] d, logic [15:0] s, logic [15:0] sl,
               logic [15:0] bw);
    wait_idle();
    cfg_write(REG_TENSION, t);
    cfg_write(REG_DAMPENING, d);
    cfg_write(REG_SPREAD, s);
    cfg_write(REG_SEA_LEVEL, sl);
    cfg_write(REG_BAR_WIDTH, bw);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random backpressure plus one long hold-off
  initial begin
    int g;
    out_ready = 1'b0;
    held_off  = 1'b0;
    @(negedge rst);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!held_off && board.checked >= 200) begin
        held_off  = 1'b1;
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(spring_index, height, last);
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 20000) begin
        $display("Watchdog expired at %0t", $time);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    board = new();
    board.reset_state();
    rst            = 1'b1;
    in_valid       = 1'b0;
    opcode         = OP_TICK;
    touch_x        = '0;
    touch_velocity = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: saturation, ties, clamping at reset settings
    send_item(OP_TOUCH, 16'd0,     32'sh7FFFFFFF);
    send_item(OP_TOUCH, 16'd0,     32'sh7FFFFFFF);
    send_item(OP_TOUCH, 16'd8,     32'sh80000000);
    send_item(OP_TOUCH, 16'd9,     32'sh00010000);
    send_item(OP_TOUCH, 16'd65535, 32'sh12345678);
    send_item(OP_TOUCH, 16'd1008,  -32'sh00200000);
    send_item(OP_TICK,  16'hFFFF,  32'shFFFFFFFF);
    send_item(OP_TICK,  16'd0,     32'sh0);
    send_item(OP_TOUCH, 16'd24,    32'sh80000000);
    send_item(OP_TOUCH, 16'd24,    32'sh80000000);
    send_item(OP_TICK,  16'h5555,  32'shAAAAAAAA);
    send_item(OP_TICK,  16'hAAAA,  32'sh55555555);
    send_random(50);

    // upper extremes, bar width of one pixel
    cfg_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd4095, 16'd1);
    send_item(OP_TOUCH, 16'd63, 32'sh7FFFFFFF);
    send_item(OP_TICK, 16'd0, 32'sh0);
    send_random(50);

    // lower extremes, zero bar width sends every touch to spring zero
    cfg_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_TOUCH, 16'd40000, 32'sh00050000);
    send_item(OP_TICK, 16'd0, 32'sh0);
    send_random(50);

    // wide bar (top bit of the width field), bits above each field, and writes to unused indexes
    cfg_all(16'd3000, 16'd800, 16'd12000, 16'hFFFF, 16'h1000);
    wait_idle();
    cfg_write(3'd5, 16'hFFFF);
    cfg_write(3'd7, 16'h1234);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_item(OP_TOUCH, 16'd2048, 32'sh00100000);
    send_item(OP_TOUCH, 16'd2049, 32'sh00100000);
    send_random(50);
    cfg_all(16'd500, 16'd500, 16'd20000, 16'hF123, 16'hE005);
    send_random(50);

    // random settings, then the reset settings again
    cfg_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    send_random(50);
    cfg_all(16'd1638, 16'd1638, 16'd16384, 16'd384, 16'd16);
    send_random(50);

    wait_idle();
    repeat (100) @(posedge clk);
    $display("Covered %0d touch and %0d tick transactions, %0d heights checked,",
             board.touches, board.ticks, board.checked);
    $display("over seven register settings including zero and full scale.");
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
